### rtl/core/ssru_pkg.sv
// Shared types and constants for the segmented scan reduce unit.
`timescale 1ns / 1ps

package ssru_pkg;

   localparam int unsigned OP_WIDTH  = 3;
   localparam int unsigned IO_WIDTH  = 32;
   localparam int unsigned CSR_IDX_WIDTH  = 1;
   localparam int unsigned CSR_DATA_WIDTH = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 3'd0,
      OP_MUL = 3'd1,
      OP_MIN = 3'd2,
      OP_MAX = 3'd3,
      OP_AND = 3'd4,
      OP_OR  = 3'd5,
      OP_XOR = 3'd6
   } op_type;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OPERATION    = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_USE_SEGMENTS = 1'b1;

endpackage

### rtl/core/ssru_combine.sv
// Operator unit: identity value and one combine step for the selected operator.
`timescale 1ns / 1ps

module ssru_combine #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic [ssru_pkg::OP_WIDTH-1:0] op,
   input  logic [DATA_WIDTH-1:0]         lhs,
   input  logic [DATA_WIDTH-1:0]         rhs,
   output logic [DATA_WIDTH-1:0]         identity,
   output logic [DATA_WIDTH-1:0]         result
);

   localparam logic [DATA_WIDTH-1:0] ALL_ONES = {DATA_WIDTH{1'b1}};
   localparam logic [DATA_WIDTH-1:0] MAX_POS  = ALL_ONES >> 1;
   localparam logic [DATA_WIDTH-1:0] MIN_NEG  = ~MAX_POS;
   localparam logic [DATA_WIDTH-1:0] ONE      = DATA_WIDTH'(1);

   logic rhs_less;
   logic [DATA_WIDTH-1:0] product;

   assign rhs_less = $signed(rhs) < $signed(lhs);
   assign product  = lhs * rhs;

   always_comb begin
      case (op)
         ssru_pkg::OP_MUL: identity = ONE;
         ssru_pkg::OP_MIN: identity = MAX_POS;
         ssru_pkg::OP_MAX: identity = MIN_NEG;
         ssru_pkg::OP_AND: identity = ALL_ONES;
         default:          identity = '0;
      endcase
   end

   always_comb begin
      case (op)
         ssru_pkg::OP_MUL: result = product;
         ssru_pkg::OP_MIN: result = rhs_less ? rhs : lhs;
         ssru_pkg::OP_MAX: result = rhs_less ? lhs : rhs;
         ssru_pkg::OP_AND: result = lhs & rhs;
         ssru_pkg::OP_OR:  result = lhs | rhs;
         ssru_pkg::OP_XOR: result = lhs ^ rhs;
         default:          result = lhs + rhs;
      endcase
   end

endmodule

### rtl/core/segmented_scan_reduce_unit.sv
// Top level of the segmented exclusive prefix scan unit.
//
// Elements enter on the req_ channel, one per transfer, with a segment-start
// and a last-of-vector flag. Each element yields one transfer on the rsp_
// channel carrying its exclusive prefix, the total of a segment that its
// start flag closed, and the running total of its segment including itself.
// The csr_ port selects the operator and whether start flags are honored.
// Users must write it only while no element is in flight; nothing enforces it.
// An element is held in an input register, then combined with the running
// value and written to the result register, from which its result is
// offered. One element is taken every cycle while rsp_stall does not hold
// the result; the rate is set by the loop from the running value through
// the operator unit back into the running value.
// Reset empties both registers, selects add with segmenting enabled, and
// makes the next element open a new vector.
// While rsp_stall is high the result holds; one more element may wait in
// the input register, after which req_stall is raised.
`timescale 1ns / 1ps

module segmented_scan_reduce_unit #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [ssru_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [ssru_pkg::CSR_DATA_WIDTH-1:0]   csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ssru_pkg::IO_WIDTH-1:0]  req_element,
   input  logic                                  req_seg_start,
   input  logic                                  req_vector_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ssru_pkg::IO_WIDTH-1:0]  rsp_prefix,
   output logic signed [ssru_pkg::IO_WIDTH-1:0]  rsp_closed_total,
   output logic                                  rsp_closed_valid,
   output logic signed [ssru_pkg::IO_WIDTH-1:0]  rsp_final_total,
   output logic                                  rsp_final_valid
);

   localparam int unsigned IO_WIDTH = ssru_pkg::IO_WIDTH;

   logic [ssru_pkg::OP_WIDTH-1:0] operation_ff;
   logic                          use_segments_ff;

   logic                  in_valid_ff, in_valid_in;
   logic [DATA_WIDTH-1:0] in_element_ff;
   logic                  in_seg_start_ff;
   logic                  in_last_ff;

   logic [DATA_WIDTH-1:0] running_ff;
   logic                  fresh_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IO_WIDTH-1:0]   rsp_prefix_ff;
   logic [IO_WIDTH-1:0]   rsp_closed_total_ff;
   logic                  rsp_closed_valid_ff;
   logic [IO_WIDTH-1:0]   rsp_final_total_ff;
   logic                  rsp_final_valid_ff;

   logic                  advance;
   logic                  load_in;
   logic                  fire;
   logic                  seg_flag;
   logic                  seg_open;
   logic                  seg_closed;
   logic [DATA_WIDTH-1:0] identity;
   logic [DATA_WIDTH-1:0] prefix_value;
   logic [DATA_WIDTH-1:0] after;
   logic [63:0]           element_wide;
   logic [63:0]           prefix_wide;
   logic [63:0]           after_wide;
   logic [63:0]           running_wide;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign load_in   = !in_valid_ff || advance;
   assign fire      = in_valid_ff && advance;
   assign req_stall = !load_in;

   assign in_valid_in  = load_in ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   assign element_wide = 64'(req_element);
   assign seg_flag     = use_segments_ff && in_seg_start_ff;
   assign seg_open     = fresh_ff || seg_flag;
   assign seg_closed   = seg_flag && !fresh_ff;
   assign prefix_value = seg_open ? identity : running_ff;

   ssru_combine #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_combine (
      .op       (operation_ff),
      .lhs      (prefix_value),
      .rhs      (in_element_ff),
      .identity (identity),
      .result   (after)
   );

   assign prefix_wide  = 64'($signed(prefix_value));
   assign after_wide   = 64'($signed(after));
   assign running_wide = 64'($signed(running_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff    <= ssru_pkg::OP_ADD;
         use_segments_ff <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            ssru_pkg::CSR_OPERATION:    operation_ff    <= csr_data;
            ssru_pkg::CSR_USE_SEGMENTS: use_segments_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            fresh_ff <= in_last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_element_ff   <= element_wide[DATA_WIDTH-1:0];
         in_seg_start_ff <= req_seg_start;
         in_last_ff      <= req_vector_last;
      end
      if (fire) begin
         running_ff          <= after;
         rsp_prefix_ff       <= prefix_wide[IO_WIDTH-1:0];
         rsp_closed_total_ff <= seg_closed ? running_wide[IO_WIDTH-1:0] : '0;
         rsp_closed_valid_ff <= seg_closed;
         rsp_final_total_ff  <= after_wide[IO_WIDTH-1:0];
         rsp_final_valid_ff  <= in_last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_prefix       = rsp_prefix_ff;
   assign rsp_closed_total = rsp_closed_total_ff;
   assign rsp_closed_valid = rsp_closed_valid_ff;
   assign rsp_final_total  = rsp_final_total_ff;
   assign rsp_final_valid  = rsp_final_valid_ff;

endmodule

### rtl/core/ssru_checker.sv
// Port-level checks for the segmented scan reduce unit and their binding.
`timescale 1ns / 1ps

module ssru_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [ssru_pkg::IO_WIDTH-1:0]  rsp_prefix,
   input logic signed [ssru_pkg::IO_WIDTH-1:0]  rsp_closed_total,
   input logic                                  rsp_closed_valid,
   input logic                                  rsp_final_valid
);

   logic after_last_ff;

   // Tracks whether the previous result transfer ended a vector.
   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
         after_last_ff <= rsp_final_valid;
      end
   end

   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_prefix))
      else $error("Stalled result changed.");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result offered right after reset.");

   a_closed_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_closed_valid |-> rsp_closed_total == '0)
      else $error("Closed total is nonzero without a closed segment.");

   a_vector_start_not_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && after_last_ff |-> !rsp_closed_valid)
      else $error("First element of a vector closed a segment.");

endmodule

bind segmented_scan_reduce_unit ssru_checker u_ssru_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_prefix       (rsp_prefix),
   .rsp_closed_total (rsp_closed_total),
   .rsp_closed_valid (rsp_closed_valid),
   .rsp_final_valid  (rsp_final_valid)
);
